@@ src/bps_pkg.sv @@
// Package for the Boltzmann partner selection block: codes, state and command types,
// fixed-point constants and the exp step table.
// Depends on nothing; used by bps_ctrl, bps_dp and the top level.
package bps_pkg;

  // Default population store depth
  localparam int POP_MAX_DEF = 64;

  // Configuration register indexes
  localparam logic CFG_POP_SIZE = 1'b0;
  localparam logic CFG_INV_TEMP = 1'b1;

  // Reset values of the configuration registers
  localparam logic [6:0]  POP_SIZE_RST = 7'd64;
  localparam logic [23:0] INV_TEMP_RST = 24'd6489;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FWD  = 2'd1,
    OP_BWD  = 2'd2
  } op_t;

  // Fixed-point constants
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;     // log2(e), Q.16
  localparam logic [29:0] LN2_Q30   = 30'd744261118; // ln(2), Q.30
  localparam logic [39:0] X_CAP     = 40'd2621440;   // 40.0 in Q.16

  // Exp step table: entry k is 2^(-2^-k) in Q.30, built by a chain of floor roots
  typedef logic [16:1][29:0] exp_tab_t;

  function automatic logic [31:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_v;
    int i;
    rem   = v;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res[31:0];
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] e;
    int k;
    e = 64'd1 << 29;
    for (k = 1; k <= 16; k++) begin
      e = {32'd0, isqrt64(e << 30)};
      tab[k] = e[29:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHK,
    ST_MIN_RD,
    ST_MIN_UPD,
    ST_SUM_RD,
    ST_SUM_X,
    ST_SUM_Y,
    ST_SUM_EXP,
    ST_SUM_ACC,
    ST_PROD,
    ST_NORM,
    ST_LN_SQ,
    ST_LN_MUL,
    ST_ROUL_RD,
    ST_ROUL_CHK,
    ST_PX_RD,
    ST_PX_X,
    ST_OUT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic fit_wr;
    logic req_load;
    logic idx_clr;
    logic idx_inc;
    logic rd_fit;
    logic rd_part;
    logic min_upd;
    logic x_load;
    logic y_load;
    logic exp_step;
    logic acc;
    logic prod;
    logic norm_step;
    logic ln_init;
    logic sq_step;
    logic ln_mul;
    logic roul_init;
    logic rd_w;
    logic roul_chk;
    logic part_b;
    logic out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic idx_skip;
    logic idx_last;
    logic k_last;
    logic norm_done;
    logic hit;
    logic fwd;
    logic bad;
  } sts_t;

endpackage

@@ src/bps_ctrl.sv @@
// Controller of the Boltzmann partner selection block: request sequencing FSM and
// output valid. Depends on bps_pkg.
module bps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_operation,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  bps_pkg::sts_t sts,
  output bps_pkg::cmd_t cmd
);

  bps_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // State and valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != bps_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      bps_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_operation)
            bps_pkg::OP_LOAD: cmd.fit_wr = 1'b1;
            bps_pkg::OP_FWD, bps_pkg::OP_BWD: begin
              cmd.req_load = 1'b1;
              state_nxt    = bps_pkg::ST_CHK;
            end
            default: ;
          endcase
        end
      end
      bps_pkg::ST_CHK: begin
        if (sts.bad) begin
          state_nxt = bps_pkg::ST_OUT;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = bps_pkg::ST_MIN_RD;
        end
      end
      // Minimum over the members other than the first pick
      bps_pkg::ST_MIN_RD: begin
        if (sts.idx_skip) begin
          if (sts.idx_last) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = bps_pkg::ST_SUM_RD;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end else begin
          cmd.rd_fit = 1'b1;
          state_nxt  = bps_pkg::ST_MIN_UPD;
        end
      end
      bps_pkg::ST_MIN_UPD: begin
        cmd.min_upd = 1'b1;
        if (sts.idx_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = bps_pkg::ST_SUM_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = bps_pkg::ST_MIN_RD;
        end
      end
      // Weight sum, weights kept for the roulette pass
      bps_pkg::ST_SUM_RD: begin
        if (sts.idx_skip) begin
          if (sts.idx_last) state_nxt = bps_pkg::ST_PROD;
          else cmd.idx_inc = 1'b1;
        end else begin
          cmd.rd_fit = 1'b1;
          state_nxt  = bps_pkg::ST_SUM_X;
        end
      end
      bps_pkg::ST_SUM_X: begin
        cmd.x_load = 1'b1;
        state_nxt  = bps_pkg::ST_SUM_Y;
      end
      bps_pkg::ST_SUM_Y: begin
        cmd.y_load = 1'b1;
        state_nxt  = bps_pkg::ST_SUM_EXP;
      end
      bps_pkg::ST_SUM_EXP: begin
        cmd.exp_step = 1'b1;
        if (sts.k_last) state_nxt = bps_pkg::ST_SUM_ACC;
      end
      bps_pkg::ST_SUM_ACC: begin
        cmd.acc = 1'b1;
        if (sts.idx_last) begin
          state_nxt = bps_pkg::ST_PROD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = bps_pkg::ST_SUM_RD;
        end
      end
      // ln(S*N)
      bps_pkg::ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = bps_pkg::ST_NORM;
      end
      bps_pkg::ST_NORM: begin
        if (sts.norm_done) begin
          cmd.ln_init = 1'b1;
          state_nxt   = bps_pkg::ST_LN_SQ;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      bps_pkg::ST_LN_SQ: begin
        cmd.sq_step = 1'b1;
        if (sts.k_last) state_nxt = bps_pkg::ST_LN_MUL;
      end
      bps_pkg::ST_LN_MUL: begin
        cmd.ln_mul = 1'b1;
        if (sts.fwd) begin
          cmd.roul_init = 1'b1;
          state_nxt     = bps_pkg::ST_ROUL_RD;
        end else begin
          cmd.part_b = 1'b1;
          state_nxt  = bps_pkg::ST_PX_RD;
        end
      end
      // Roulette walk
      bps_pkg::ST_ROUL_RD: begin
        if (sts.idx_skip) begin
          if (sts.idx_last) state_nxt = bps_pkg::ST_PX_RD;
          else cmd.idx_inc = 1'b1;
        end else begin
          cmd.rd_w  = 1'b1;
          state_nxt = bps_pkg::ST_ROUL_CHK;
        end
      end
      bps_pkg::ST_ROUL_CHK: begin
        cmd.roul_chk = 1'b1;
        if (sts.hit || sts.idx_last) begin
          state_nxt = bps_pkg::ST_PX_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = bps_pkg::ST_ROUL_RD;
        end
      end
      // Scaled gap of the partner
      bps_pkg::ST_PX_RD: begin
        cmd.rd_part = 1'b1;
        state_nxt   = bps_pkg::ST_PX_X;
      end
      bps_pkg::ST_PX_X: begin
        cmd.x_load = 1'b1;
        state_nxt  = bps_pkg::ST_OUT;
      end
      bps_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = bps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bps_pkg::ST_IDLE;
    endcase
  end

  // Result valid: set on load, cleared once taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

endmodule

@@ src/bps_dp.sv @@
// Datapath of the Boltzmann partner selection block: config registers, fitness and
// weight stores, exp and ln units, roulette and result registers. Depends on bps_pkg.
module bps_dp #(
  parameter int POP_MAX = bps_pkg::POP_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [23:0]   cfg_data,
  input  logic [1:0]    in_operation,
  input  logic [5:0]    in_member_index,
  input  logic [31:0]   in_fitness_value,
  input  logic [5:0]    in_first_pick,
  input  logic [5:0]    in_second_pick,
  input  logic [15:0]   in_uniform_draw,
  input  bps_pkg::cmd_t cmd,
  output bps_pkg::sts_t sts,
  output logic [5:0]    out_partner,
  output logic [31:0]   out_log_prob,
  output logic          out_bad_request
);

  localparam int AW  = (POP_MAX > 1) ? $clog2(POP_MAX) : 1;
  localparam int NW  = $clog2(POP_MAX + 1);
  localparam int SW  = 31 + $clog2(POP_MAX);
  localparam int UW  = SW + 16;
  localparam int PW  = SW + NW;
  localparam int TW  = $clog2(PW);
  localparam int LW  = TW + 16;
  localparam int XW  = 40;
  localparam int TOW = ((XW > LW) ? XW : LW) + 1;

  // Config registers
  logic [6:0]  pop_r;
  logic [23:0] invt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_r  <= bps_pkg::POP_SIZE_RST;
      invt_r <= bps_pkg::INV_TEMP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bps_pkg::CFG_POP_SIZE: pop_r  <= cfg_data[6:0];
        bps_pkg::CFG_INV_TEMP: invt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stores
  logic signed [31:0] fit_mem [POP_MAX];
  logic [30:0]        w_mem   [POP_MAX];

  // Request and working registers
  logic               fwd_r;
  logic [5:0]         a_r, b_r;
  logic [15:0]        u_r;
  logic [NW-1:0]      n_r, idx_r, part_r;
  logic signed [31:0] fmin_r, rdata_r;
  logic               have_r;
  logic [XW-1:0]      x_r;
  logic               cap_r;
  logic [6:0]         q_r;
  logic [15:0]        r_r;
  logic [30:0]        m_r, la_r, wrd_r;
  logic [4:0]         k_r;
  logic [SW-1:0]      s_r, c_r;
  logic [UW-1:0]      us_r;
  logic [PW-1:0]      nrm_r;
  logic [TW-1:0]      top_r, lint_r;
  logic [15:0]        lfrac_r;
  logic [LW-1:0]      lnp_r;
  logic [5:0]         out_partner_r;
  logic [31:0]        out_log_prob_r;
  logic               out_bad_r;

  // Combinational helpers
  logic [NW-1:0]  n_clamp, nm1, part_def;
  logic           ld_ok;
  logic [32:0]    diff;
  logic [55:0]    xprod;
  logic [38:0]    yprod;
  logic [60:0]    mprod;
  logic [30:0]    w;
  logic [PW-1:0]  pprod;
  logic [UW-1:0]  uprod;
  logic [61:0]    sqprod;
  logic [31:0]    sq;
  logic [LW+29:0] lnprod;
  logic [SW-1:0]  c_nxt;
  logic [TOW-1:0] tot;
  logic [31:0]    lp;

  always_comb begin
    // Population size saturated into range
    if (pop_r < 7'd2) n_clamp = NW'(2);
    else if (32'(pop_r) > POP_MAX) n_clamp = NW'(POP_MAX);
    else n_clamp = NW'(pop_r);
    ld_ok    = 32'(in_member_index) < POP_MAX;
    nm1      = n_r - NW'(1);
    part_def = (NW'(a_r) == nm1) ? n_r - NW'(2) : nm1;

    // Scaled gap x = ((f - fmin) * 1/T) >> 16
    diff  = {rdata_r[31], rdata_r} - {fmin_r[31], fmin_r};
    xprod = 56'(diff[31:0]) * 56'(invt_r);
    // x * log2(e)
    yprod = 39'(x_r[21:0]) * 39'(bps_pkg::LOG2E_Q16);
    // One fraction bit of the exp
    mprod = 61'(m_r) * 61'(bps_pkg::EXP_TAB[k_r]);
    w     = (cap_r || q_r >= 7'd63) ? '0 : (m_r >> q_r);

    pprod  = PW'(s_r) * PW'(n_r);
    uprod  = UW'(s_r) * UW'(u_r);
    sqprod = 62'(la_r) * 62'(la_r);
    sq     = sqprod[61:30];
    lnprod = (LW + 30)'({lint_r, lfrac_r}) * (LW + 30)'(bps_pkg::LN2_Q30)
           + (LW + 30)'(32'd1 << 29);

    c_nxt = c_r + SW'(wrd_r);

    // log_prob = -(x + ln(S*N)), saturated
    tot = TOW'(x_r) + TOW'(lnp_r);
    if (tot >= TOW'(33'h1_0000_0000 >> 1)) lp = 32'h8000_0000;
    else lp = 32'd0 - tot[31:0];
  end

  // Status
  always_comb begin
    sts.idx_skip  = (idx_r == NW'(a_r));
    sts.idx_last  = (idx_r == nm1);
    sts.k_last    = (k_r == 5'd16);
    sts.norm_done = nrm_r[PW-1];
    sts.hit       = {c_nxt, 16'd0} > us_r;
    sts.fwd       = fwd_r;
    sts.bad       = (32'(a_r) >= 32'(n_r))
                  || (!fwd_r && ((32'(b_r) >= 32'(n_r)) || (a_r == b_r)));
  end

  // Store access
  always_ff @(posedge clk) begin
    if (cmd.fit_wr && ld_ok) fit_mem[AW'(in_member_index)] <= in_fitness_value;
    if (cmd.rd_fit) rdata_r <= fit_mem[idx_r[AW-1:0]];
    else if (cmd.rd_part) rdata_r <= fit_mem[part_r[AW-1:0]];
    if (cmd.acc) w_mem[idx_r[AW-1:0]] <= w;
    if (cmd.rd_w) wrd_r <= w_mem[idx_r[AW-1:0]];
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      fwd_r  <= (in_operation == bps_pkg::OP_FWD);
      a_r    <= in_first_pick;
      b_r    <= in_second_pick;
      u_r    <= in_uniform_draw;
      n_r    <= n_clamp;
      have_r <= 1'b0;
      s_r    <= '0;
    end
    if (cmd.idx_clr) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + NW'(1);

    if (cmd.min_upd && (!have_r || rdata_r < fmin_r)) begin
      fmin_r <= rdata_r;
      have_r <= 1'b1;
    end

    if (cmd.x_load) x_r <= xprod[55:16];
    if (cmd.y_load) begin
      cap_r <= (x_r >= bps_pkg::X_CAP);
      q_r   <= yprod[38:32];
      r_r   <= yprod[31:16];
      m_r   <= 31'h4000_0000;
    end
    if (cmd.exp_step) begin
      if (r_r[15]) m_r <= mprod[60:30];
      r_r <= r_r << 1;
    end
    if (cmd.acc) s_r <= s_r + SW'(w);

    // Normalize S*N, then square-and-compare for the fraction of log2
    if (cmd.prod) begin
      nrm_r <= pprod;
      top_r <= TW'(PW - 1);
      us_r  <= uprod;
    end
    if (cmd.norm_step) begin
      nrm_r <= nrm_r << 1;
      top_r <= top_r - TW'(1);
    end
    if (cmd.ln_init) begin
      la_r    <= nrm_r[PW-1 -: 31];
      lint_r  <= top_r - TW'(30);
      lfrac_r <= '0;
    end
    if (cmd.sq_step) begin
      la_r    <= sq[31] ? sq[31:1] : sq[30:0];
      lfrac_r <= {lfrac_r[14:0], sq[31]};
    end
    if (cmd.ln_mul) lnp_r <= lnprod[LW+29:30];

    // Exp and ln share the step counter
    if (cmd.y_load || cmd.ln_init) k_r <= 5'd1;
    else if (cmd.exp_step || cmd.sq_step) k_r <= k_r + 5'd1;

    // Roulette
    if (cmd.roul_init) begin
      c_r    <= '0;
      part_r <= part_def;
      idx_r  <= '0;
    end
    if (cmd.roul_chk) begin
      c_r <= c_nxt;
      if (sts.hit) part_r <= idx_r;
    end
    if (cmd.part_b) part_r <= NW'(b_r);

    // Result register
    if (cmd.out_load) begin
      if (sts.bad) begin
        out_partner_r  <= fwd_r ? 6'd0 : b_r;
        out_log_prob_r <= '0;
        out_bad_r      <= 1'b1;
      end else begin
        out_partner_r  <= 6'(part_r);
        out_log_prob_r <= lp;
        out_bad_r      <= 1'b0;
      end
    end
  end

  assign out_partner     = out_partner_r;
  assign out_log_prob    = out_log_prob_r;
  assign out_bad_request = out_bad_r;

endmodule

@@ src/boltzmann_partner_selection.sv @@
// Top level of the Boltzmann partner selection block: joins controller and datapath.
// Depends on bps_pkg, bps_ctrl and bps_dp.
//
//   channel | direction | handshake          | payload
//   in_     | request   | in_valid/in_stall   | operation, member_index, fitness_value,
//           |           |                     | first_pick, second_pick, uniform_draw
//   out_    | result    | out_valid/out_stall | partner, log_prob, bad_request
//   cfg_    | write     | cfg_we              | cfg_index, cfg_data
//
// A load request writes the store and leaves the block idle. A forward request runs a
// minimum pass, a weight pass and a roulette pass over the members, plus ln: in the weight
// pass each member is read, scaled and put through the single exp multiplier, stepping
// one fraction bit per cycle, then accumulated; ln takes up to 12 normalize shifts and 16
// squarings. Backward requests skip the roulette pass. A bad request goes straight to the
// result. A stalled result is held in the output register; a later result waits in
// ST_OUT with in_stall high until it is taken. Reset is synchronous, active low; the
// fitness store is not cleared.
module boltzmann_partner_selection #(
  parameter int POP_MAX = bps_pkg::POP_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [5:0]  in_member_index,
  input  logic [31:0] in_fitness_value,
  input  logic [5:0]  in_first_pick,
  input  logic [5:0]  in_second_pick,
  input  logic [15:0] in_uniform_draw,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_partner,
  output logic [31:0] out_log_prob,
  output logic        out_bad_request
);

  bps_pkg::cmd_t cmd;
  bps_pkg::sts_t sts;

  bps_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  bps_dp #(
    .POP_MAX (POP_MAX)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_operation     (in_operation),
    .in_member_index  (in_member_index),
    .in_fitness_value (in_fitness_value),
    .in_first_pick    (in_first_pick),
    .in_second_pick   (in_second_pick),
    .in_uniform_draw  (in_uniform_draw),
    .cmd              (cmd),
    .sts              (sts),
    .out_partner      (out_partner),
    .out_log_prob     (out_log_prob),
    .out_bad_request  (out_bad_request)
  );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for boltzmann_partner_selection: directed table, then random
// phases over several register settings, checked against a cycle-free predictor.
// Depends on bps_pkg and the RTL under src.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         LIMIT = 4000000;
  localparam int         HOLD_CYCLES = 3000;
  localparam int         SETTLE = 20;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  idx;
    logic [31:0] fit;
    logic [5:0]  first;
    logic [5:0]  second;
    logic [15:0] draw;
  } request_t;

  typedef struct packed {
    logic [5:0]  partner;
    logic [31:0] log_prob;
    logic        bad;
  } pair_t;

  typedef struct {
    int       set_pop;
    int       set_temp;
    request_t req;
    bit       typed;
    pair_t    res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [23:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [5:0]  in_member_index;
  logic [31:0] in_fitness_value;
  logic [5:0]  in_first_pick;
  logic [5:0]  in_second_pick;
  logic [15:0] in_uniform_draw;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  out_partner;
  logic [31:0] out_log_prob;
  logic        out_bad_request;

  // Predictor state
  longint          fit_mem [64];
  longint unsigned pop_reg;
  longint unsigned temp_reg;
  longint unsigned exp_step [17];

  pair_t pending_pairs [$];
  pair_t typed_pairs [$];
  bit    typed_flags [$];

  bit          idle_on;
  bit          hold_req;
  int          hold_left;
  int          errors;
  int          cycles;
  int          n_req;
  int          n_bad;
  int          n_loads;
  int          n_phases;

  boltzmann_partner_selection u_top (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Floor square root
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, t;
    int k;
    r = 0;
    for (k = 31; k >= 0; k--) begin
      t = r | (longint'(1) << k);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned boltz_weight(longint unsigned x);
    longint unsigned y, q, r, m;
    int k;
    m = longint'(1) << 30;
    if (x >= (longint'(40) << 16)) return 0;
    y = (x * 94548) >> 16;
    q = y >> 16;
    r = y & 16'hFFFF;
    for (k = 1; k <= 16; k++)
      if (((r >> (16 - k)) & 1) != 0) m = (m * exp_step[k]) >> 30;
    return (q >= 63) ? 0 : (m >> q);
  endfunction

  function automatic longint unsigned ln_q16(longint unsigned p);
    int top, i;
    longint unsigned a, l;
    top = 63;
    while (top > 0 && ((p >> top) & 1) == 0) top--;
    a = p >> (top - 30);
    l = longint'(top - 30) << 16;
    for (i = 15; i >= 0; i--) begin
      a = (a * a) >> 30;
      if (a >= (longint'(1) << 31)) begin
        a = a >> 1;
        l = l | (longint'(1) << i);
      end
    end
    return (l * 744261118 + (longint'(1) << 29)) >> 30;
  endfunction

  function automatic longint unsigned scaled_gap(longint f, longint fmin);
    longint unsigned d;
    d = f - fmin;
    return (d * temp_reg) >> 16;
  endfunction

  // Predict the result of one accepted request; loads update the store
  function automatic void predict_pair(input request_t r, output bit has, output pair_t res);
    longint unsigned n, a, b, s, c, part;
    longint fmin, lp;
    bit seen;
    int i;
    has = 1'b0;
    res = '0;
    if (r.op == bps_pkg::OP_LOAD) begin
      fit_mem[r.idx] = longint'($signed(r.fit));
      return;
    end
    if (r.op == OP_UNUSED) return;
    has = 1'b1;
    n = pop_reg;
    if (n < 2) n = 2;
    if (n > 64) n = 64;
    a = r.first;
    b = r.second;
    if (a >= n || (r.op == bps_pkg::OP_BWD && (b >= n || a == b))) begin
      res.partner = (r.op == bps_pkg::OP_BWD) ? r.second : 6'd0;
      res.bad = 1'b1;
      return;
    end
    seen = 0;
    fmin = 0;
    for (i = 0; i < n; i++)
      if (i != a && (!seen || fit_mem[i] < fmin)) begin
        fmin = fit_mem[i];
        seen = 1;
      end
    s = 0;
    for (i = 0; i < n; i++)
      if (i != a) s += boltz_weight(scaled_gap(fit_mem[i], fmin));
    if (r.op == bps_pkg::OP_FWD) begin
      // overshoot falls on the last eligible member
      part = (a == n - 1) ? n - 2 : n - 1;
      c = 0;
      for (i = 0; i < n; i++) begin
        if (i == a) continue;
        c += boltz_weight(scaled_gap(fit_mem[i], fmin));
        if ((c << 16) > longint'(r.draw) * s) begin
          part = i;
          break;
        end
      end
    end else begin
      part = b;
    end
    lp = -longint'(scaled_gap(fit_mem[part], fmin)) - longint'(ln_q16(s * n));
    if (lp < -64'sd2147483648) lp = -64'sd2147483648;
    res.partner = part[5:0];
    res.log_prob = lp[31:0];
  endfunction

  // Request acceptance: predict and queue
  always @(posedge clk) begin
    pair_t res;
    bit has;
    request_t r;
    bit use_typed;
    pair_t typed;
    if (rst_n && in_valid && !in_stall) begin
      r = '{in_operation, in_member_index, in_fitness_value, in_first_pick,
            in_second_pick, in_uniform_draw};
      use_typed = typed_flags.pop_front();
      typed = typed_pairs.pop_front();
      predict_pair(r, has, res);
      if (has) begin
        pending_pairs.push_back(use_typed ? typed : res);
        n_req++;
        if (res.bad) n_bad++;
      end else if (r.op == bps_pkg::OP_LOAD) begin
        n_loads++;
      end
    end
  end

  // Result check
  always @(posedge clk) begin
    pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected result partner=%0d log_prob=%h bad=%b", $realtime,
                 out_partner, out_log_prob, out_bad_request);
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_partner !== want.partner) begin
          $display("%0t: partner expected %0d actual %0d", $realtime, want.partner,
                   out_partner);
          errors++;
        end
        if (out_log_prob !== want.log_prob) begin
          $display("%0t: log_prob expected %h actual %h", $realtime, want.log_prob,
                   out_log_prob);
          errors++;
        end
        if (out_bad_request !== want.bad) begin
          $display("%0t: bad_request expected %b actual %b", $realtime, want.bad,
                   out_bad_request);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 33);
      end
    end
  end

  // Offer one request and wait for it to be taken; called at a clock edge
  task automatic send_request(input request_t r, input bit typed, input pair_t res);
    if (idle_on && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 33) @(posedge clk);
    end
    typed_flags.push_back(typed);
    typed_pairs.push_back(res);
    in_valid <= 1'b1;
    in_operation <= r.op;
    in_member_index <= r.idx;
    in_fitness_value <= r.fit;
    in_first_pick <= r.first;
    in_second_pick <= r.second;
    in_uniform_draw <= r.draw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input longint unsigned val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[23:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bps_pkg::CFG_POP_SIZE) pop_reg = val & 7'h7F;
    else temp_reg = val & 24'hFFFFFF;
  endtask

  function automatic row_t mk(int sp, int st, logic [1:0] op, int idx, logic [31:0] fit,
                              int a, int b, int u, bit typed, pair_t res);
    row_t w;
    w.set_pop = sp;
    w.set_temp = st;
    w.req = '{op, idx[5:0], fit, a[5:0], b[5:0], u[15:0]};
    w.typed = typed;
    w.res = res;
    return w;
  endfunction

  function automatic logic [31:0] rand_fitness(logic [31:0] base);
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return base + $urandom_range(0, 32'h0000_FFFF);
      2:       return base + $urandom_range(0, 32'h000F_FFFF);
      default: return base + $urandom_range(0, 32'h00FF_FFFF);
    endcase
  endfunction

  // Stimulus
  initial begin
    row_t     rows [$];
    row_t     w;
    request_t r;
    pair_t    none;
    int       i, k, nreq, n_eff, ph, items;
    logic [31:0] base;
    longint unsigned pv, tv;

    none = '0;
    idle_on = 1'b1;
    hold_req = 0;
    errors = 0;
    cycles = 0;
    n_req = 0;
    n_bad = 0;
    n_loads = 0;
    n_phases = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = bps_pkg::CFG_POP_SIZE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_operation = bps_pkg::OP_LOAD;
    in_member_index = '0;
    in_fitness_value = '0;
    in_first_pick = '0;
    in_second_pick = '0;
    in_uniform_draw = '0;
    exp_step[0] = longint'(1) << 29;
    for (k = 1; k <= 16; k++) exp_step[k] = root_floor(exp_step[k - 1] << 30);
    for (k = 0; k < 64; k++) fit_mem[k] = 0;
    pop_reg = 64;
    temp_reg = 6489;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole store so no unwritten entry is ever read
    for (k = 0; k < 64; k++) begin
      r = '{bps_pkg::OP_LOAD, k[5:0], 32'(k * 32'h0000_8000) ^ ($urandom & 32'h0003_FFFF),
            6'd0, 6'd0, 16'd0};
      if (k == 0) r.fit = 32'h8000_0000;
      if (k == 1) r.fit = 32'h7FFF_FFFF;
      send_request(r, 0, none);
    end

    // Directed table: extremes, every operation, bad picks, saturated registers
    rows.push_back(mk(-1, -1, bps_pkg::OP_FWD, 0, 0, 0, 0, 0, 0, none));
    rows.push_back(mk(-1, -1, bps_pkg::OP_FWD, 0, 0, 1, 0, 65535, 0, none));
    rows.push_back(mk(-1, -1, bps_pkg::OP_FWD, 0, 0, 63, 0, 32768, 0, none));
    rows.push_back(mk(-1, -1, bps_pkg::OP_BWD, 0, 0, 0, 1, 0, 0, none));
    rows.push_back(mk(-1, -1, bps_pkg::OP_BWD, 0, 0, 1, 0, 0, 0, none));
    rows.push_back(mk(-1, -1, bps_pkg::OP_BWD, 0, 0, 5, 5, 0, 1, '{6'd5, 32'd0, 1'b1}));
    rows.push_back(mk(-1, -1, OP_UNUSED, 7, 32'h1234_5678, 3, 4, 9, 0, none));
    rows.push_back(mk(-1, -1, bps_pkg::OP_LOAD, 63, 32'hFFFF_FFFF, 0, 0, 0, 0, none));
    rows.push_back(mk(-1, -1, bps_pkg::OP_FWD, 0, 0, 2, 0, 65535, 0, none));
    rows.push_back(mk(5, -1, bps_pkg::OP_FWD, 0, 0, 63, 0, 100, 1, '{6'd0, 32'd0, 1'b1}));
    rows.push_back(mk(-1, -1, bps_pkg::OP_BWD, 0, 0, 1, 40, 0, 1, '{6'd40, 32'd0, 1'b1}));
    rows.push_back(mk(-1, -1, bps_pkg::OP_BWD, 0, 0, 40, 1, 0, 1, '{6'd1, 32'd0, 1'b1}));
    rows.push_back(mk(-1, -1, bps_pkg::OP_FWD, 0, 0, 4, 0, 65535, 0, none));
    rows.push_back(mk(-1, -1, bps_pkg::OP_BWD, 0, 0, 4, 3, 0, 0, none));
    rows.push_back(mk(0, -1, bps_pkg::OP_FWD, 0, 0, 0, 0, 0, 0, none));
    rows.push_back(mk(-1, -1, bps_pkg::OP_FWD, 0, 0, 2, 0, 0, 1, '{6'd0, 32'd0, 1'b1}));
    rows.push_back(mk(-1, -1, bps_pkg::OP_BWD, 0, 0, 1, 0, 0, 0, none));
    rows.push_back(mk(-1, 0, bps_pkg::OP_FWD, 0, 0, 0, 1, 40000, 0, none));
    rows.push_back(mk(127, 16777215, bps_pkg::OP_FWD, 0, 0, 10, 0, 1, 0, none));
    rows.push_back(mk(-1, -1, bps_pkg::OP_BWD, 0, 0, 10, 20, 0, 0, none));
    foreach (rows[i]) begin
      w = rows[i];
      if (w.set_pop >= 0) write_reg(bps_pkg::CFG_POP_SIZE, w.set_pop);
      if (w.set_temp >= 0) write_reg(bps_pkg::CFG_INV_TEMP, w.set_temp);
      send_request(w.req, w.typed, w.res);
    end

    // Random phases: mostly small populations, a few large ones
    items = 0;
    ph = 0;
    while (items < 1250) begin
      case (ph % 7)
        0:       pv = $urandom_range(2, 8);
        1:       pv = $urandom_range(2, 16);
        2:       pv = (ph % 3 == 0) ? 64 : 2;
        3:       pv = $urandom_range(0, 1);
        4:       pv = $urandom_range(65, 127);
        5:       pv = $urandom_range(2, 24);
        default: pv = $urandom_range(2, 6);
      endcase
      case ($urandom_range(0, 5))
        0:       tv = 0;
        1:       tv = 24'hFFFFFF;
        2:       tv = 6489;
        3:       tv = $urandom_range(1, 24'h00FFFF);
        default: tv = $urandom & 24'hFFFFFF;
      endcase
      write_reg(bps_pkg::CFG_POP_SIZE, pv);
      write_reg(bps_pkg::CFG_INV_TEMP, tv);
      n_phases++;
      n_eff = int'((pv < 2) ? 2 : (pv > 64) ? 64 : pv);
      nreq = (n_eff >= 32) ? 8 : 70;
      base = $urandom;
      // Reload the members in use with a fresh landscape
      for (k = 0; k < n_eff; k++) begin
        r = '{bps_pkg::OP_LOAD, k[5:0], rand_fitness(base), 6'($urandom), 6'($urandom),
              16'($urandom)};
        send_request(r, 0, none);
      end
      for (k = 0; k < nreq; k++) begin
        idle_on = !(items >= 400 && items < 700);
        if (items == 200) hold_req = 1;
        r.op = ($urandom_range(0, 99) < 45) ? bps_pkg::OP_FWD : bps_pkg::OP_BWD;
        i = $urandom_range(0, 99);
        if (i < 12) r.op = bps_pkg::OP_LOAD;
        else if (i < 16) r.op = OP_UNUSED;
        r.idx = 6'($urandom);
        r.fit = rand_fitness(base);
        r.first = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, n_eff - 1));
        r.second = ($urandom_range(0, 9) == 0) ? 6'($urandom)
                                                : 6'($urandom_range(0, n_eff - 1));
        r.draw = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
        send_request(r, 0, none);
        items++;
      end
      ph++;
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d result requests (%0d with bad picks) and %0d loads", n_req, n_bad,
             n_loads);
    $display("over %0d register settings, with random stalls and one long hold-off",
             n_phases);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
